// ===== sv/lge_pkg.sv =====
// Package: shared types and constants of the life generation engine.
`timescale 1ns / 1ps

package lge_pkg;

   localparam int MAX_COLS  = 64;
   localparam int MAX_ROWS  = 64;
   localparam int ROW_AW    = 6;
   localparam int CNT_W     = 7;
   localparam int GEN_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   typedef logic [MAX_COLS-1:0] row_type;
   typedef logic [ROW_AW-1:0]   row_addr_type;
   typedef logic [CNT_W-1:0]    row_cnt_type;
   typedef logic [GEN_W-1:0]    gen_cnt_type;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GENERATIONS = 2'd2;

   localparam row_cnt_type COLS_RESET = 7'd64;
   localparam row_cnt_type ROWS_RESET = 7'd64;

   // Grid RAM port bundle: one write and one read per cycle.
   typedef struct packed {
      logic         wr_en;
      row_addr_type wr_addr;
      row_type      wr_data;
      row_addr_type rd_addr;
   } ram_req_type;

endpackage

// ===== sv/lge_grid_ram.sv =====
// Grid storage: 64 rows of 64 cells, one write port and one registered read port.
`timescale 1ns / 1ps

module lge_grid_ram (
   input  logic                 clock,
   input  lge_pkg::ram_req_type ram_req,
   output lge_pkg::row_type     rd_data
);

   lge_pkg::row_type mem [lge_pkg::MAX_ROWS];
   lge_pkg::row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      rd_data_ff <= mem[ram_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lge_row_unit.sv =====
// Next-row evaluator: B3/S23 rule on one row from its two neighbor rows.
`timescale 1ns / 1ps

module lge_row_unit (
   input  lge_pkg::row_type above,
   input  lge_pkg::row_type current,
   input  lge_pkg::row_type below,
   input  lge_pkg::row_type col_mask,
   output lge_pkg::row_type next_row
);

   lge_pkg::row_type planes [8];
   lge_pkg::row_type s0;
   lge_pkg::row_type s1;
   lge_pkg::row_type s2;
   lge_pkg::row_type c0;
   lge_pkg::row_type c1;

   always_comb begin
      planes[0] = above << 1;
      planes[1] = above;
      planes[2] = above >> 1;
      planes[3] = current << 1;
      planes[4] = current >> 1;
      planes[5] = below << 1;
      planes[6] = below;
      planes[7] = below >> 1;
      s0 = '0;
      s1 = '0;
      s2 = '0;
      c0 = '0;
      c1 = '0;
      // bitwise counter per column: s1:s0 low bits, s2 flags four or more
      for (int p = 0; p < 8; p++) begin
         c0 = s0 & planes[p];
         s0 = s0 ^ planes[p];
         c1 = s1 & c0;
         s1 = s1 ^ c0;
         s2 = s2 | c1;
      end
      next_row = s1 & ~s2 & (s0 | current) & col_mask;
   end

endmodule

// ===== sv/life_generation_engine_core.sv =====
// Top level: Game of Life (B3/S23) grid engine with load, compute and unload sequencer.
`timescale 1ns / 1ps

// Rows of a grid arrive one request per cycle on the req_ channel and are stored in
// a 64x64 grid RAM, masked to the configured column count. The request that fills
// the configured row count starts the compute phase; req_stall is high from then
// until the unload ends. Each generation sweeps the grid once through a single
// shared next-row evaluator, fed from the RAM read port and two registers holding
// the old row above and the old current row; ST_PRIME and ST_FETCH prime the sweep,
// then each row takes one RAM read (ST_READ) and one RAM write (ST_CALC). After the
// last generation the rows are read back and emitted on the rsp_ channel from row 0,
// each through ST_OUT_READ and ST_OUT_HOLD, which waits while the response register
// is stalled; the final row is flagged by rsp_last_row and cells past the column
// count are zero. Zero generations emits the loaded grid as is. Cells outside the
// grid count as dead; nothing wraps. A row count of zero acts as one and above 64
// as 64, and likewise for the column count. Lowering the row count during a load to
// at most one more than the rows already loaded makes the next request complete the grid.
// The csr_ port is always ready; write it only while the block is idle.

module life_generation_engine_core (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [63:0]                         req_row_cells,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [63:0]                         rsp_out_cells,
   output logic [5:0]                          rsp_out_row,
   output logic                                rsp_last_row,
   // register write port
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lge_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lge_pkg::CSR_DAT_W-1:0]       csr_wdata
);

   typedef enum logic [6:0] {
      ST_LOAD     = 7'b0000001,
      ST_PRIME    = 7'b0000010,
      ST_FETCH    = 7'b0000100,
      ST_READ     = 7'b0001000,
      ST_CALC     = 7'b0010000,
      ST_OUT_READ = 7'b0100000,
      ST_OUT_HOLD = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   lge_pkg::row_cnt_type grid_cols_ff, grid_cols_in;
   lge_pkg::row_cnt_type grid_rows_ff, grid_rows_in;
   lge_pkg::gen_cnt_type generations_ff, generations_in;

   // sequencer state
   lge_pkg::row_cnt_type  rows_loaded_ff, rows_loaded_in;
   lge_pkg::gen_cnt_type  gens_left_ff, gens_left_in;
   lge_pkg::row_addr_type row_ff, row_in;
   lge_pkg::row_type      old_above_ff, old_above_in;
   lge_pkg::row_type      old_cur_ff, old_cur_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   lge_pkg::row_type      rsp_cells_ff, rsp_cells_in;
   lge_pkg::row_addr_type rsp_row_ff, rsp_row_in;
   logic                  rsp_last_ff, rsp_last_in;

   lge_pkg::ram_req_type  ram_req;
   lge_pkg::row_type      ram_rd_data;
   lge_pkg::row_type      rd_masked;
   lge_pkg::row_type      below;
   lge_pkg::row_type      next_row;
   lge_pkg::row_type      col_mask;

   lge_pkg::row_cnt_type  eff_cols;
   lge_pkg::row_cnt_type  eff_rows;
   lge_pkg::row_addr_type rows_m1;
   lge_pkg::row_addr_type load_idx;
   logic                  req_accept;
   logic                  rsp_free;
   logic                  row_is_last;

   // clamp the configured counts to 1..64
   always_comb begin
      eff_cols = grid_cols_ff;
      if (grid_cols_ff == '0) begin
         eff_cols = lge_pkg::row_cnt_type'(1);
      end else if (grid_cols_ff > lge_pkg::row_cnt_type'(lge_pkg::MAX_COLS)) begin
         eff_cols = lge_pkg::row_cnt_type'(lge_pkg::MAX_COLS);
      end
      eff_rows = grid_rows_ff;
      if (grid_rows_ff == '0) begin
         eff_rows = lge_pkg::row_cnt_type'(1);
      end else if (grid_rows_ff > lge_pkg::row_cnt_type'(lge_pkg::MAX_ROWS)) begin
         eff_rows = lge_pkg::row_cnt_type'(lge_pkg::MAX_ROWS);
      end
      for (int j = 0; j < lge_pkg::MAX_COLS; j++) begin
         col_mask[j] = (lge_pkg::row_cnt_type'(j) < eff_cols);
      end
   end

   assign rows_m1     = lge_pkg::row_addr_type'(eff_rows - lge_pkg::row_cnt_type'(1));
   assign row_is_last = (row_ff == rows_m1);

   // row count lowered mid-load: overwrite the last row
   assign load_idx = (rows_loaded_ff >= eff_rows) ? rows_m1
                                                  : rows_loaded_ff[lge_pkg::ROW_AW-1:0];

   assign req_stall  = (state_ff != ST_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   // re-mask every read so a column change mid-load takes effect
   assign rd_masked = ram_rd_data & col_mask;
   assign below     = row_is_last ? '0 : rd_masked;

   lge_grid_ram u_grid_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   lge_row_unit u_row_unit (
      .above    (old_above_ff),
      .current  (old_cur_ff),
      .below    (below),
      .col_mask (col_mask),
      .next_row (next_row)
   );

   // configuration writes
   always_comb begin
      grid_cols_in   = grid_cols_ff;
      grid_rows_in   = grid_rows_ff;
      generations_in = generations_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            lge_pkg::CSR_GRID_COLS: begin
               grid_cols_in = csr_wdata[lge_pkg::CNT_W-1:0];
            end
            lge_pkg::CSR_GRID_ROWS: begin
               grid_rows_in = csr_wdata[lge_pkg::CNT_W-1:0];
            end
            lge_pkg::CSR_GENERATIONS: begin
               generations_in = csr_wdata[lge_pkg::GEN_W-1:0];
            end
            default: begin
               // unused index: drop the write
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      rows_loaded_in = rows_loaded_ff;
      gens_left_in   = gens_left_ff;
      row_in         = row_ff;
      old_above_in   = old_above_ff;
      old_cur_in     = old_cur_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_cells_in   = rsp_cells_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_last_in    = rsp_last_ff;

      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = row_ff;
      ram_req.wr_data = next_row;
      ram_req.rd_addr = row_ff;

      // retire a taken response
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_LOAD: begin
            ram_req.wr_addr = load_idx;
            ram_req.wr_data = req_row_cells & col_mask;
            if (req_accept) begin
               ram_req.wr_en = 1'b1;
               if (load_idx == rows_m1) begin
                  // grid complete: start the generation sweeps, or the unload if there are none
                  rows_loaded_in = '0;
                  gens_left_in   = generations_ff;
                  row_in         = '0;
                  state_in       = (generations_ff == '0) ? ST_OUT_READ : ST_PRIME;
               end else begin
                  rows_loaded_in = lge_pkg::row_cnt_type'(load_idx)
                                   + lge_pkg::row_cnt_type'(1);
               end
            end
         end
         ST_PRIME: begin
            ram_req.rd_addr = '0;
            state_in        = ST_FETCH;
         end
         ST_FETCH: begin
            old_above_in = '0;
            old_cur_in   = rd_masked;
            row_in       = '0;
            state_in     = ST_READ;
         end
         ST_READ: begin
            // fetch the row below; on the last row its data is not used
            ram_req.rd_addr = row_ff + lge_pkg::row_addr_type'(1);
            state_in        = ST_CALC;
         end
         ST_CALC: begin
            ram_req.wr_en = 1'b1;
            old_above_in  = old_cur_ff;
            old_cur_in    = below;
            if (row_is_last) begin
               gens_left_in = gens_left_ff - lge_pkg::gen_cnt_type'(1);
               row_in       = '0;
               state_in     = (gens_left_ff == lge_pkg::gen_cnt_type'(1)) ? ST_OUT_READ
                                                                          : ST_PRIME;
            end else begin
               row_in   = row_ff + lge_pkg::row_addr_type'(1);
               state_in = ST_READ;
            end
         end
         ST_OUT_READ: begin
            state_in = ST_OUT_HOLD;
         end
         ST_OUT_HOLD: begin
            // hold the read address so the RAM output stays put while stalled
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_cells_in = rd_masked;
               rsp_row_in   = row_ff;
               rsp_last_in  = row_is_last;
               if (row_is_last) begin
                  row_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  row_in   = row_ff + lge_pkg::row_addr_type'(1);
                  state_in = ST_OUT_READ;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         grid_cols_ff   <= lge_pkg::COLS_RESET;
         grid_rows_ff   <= lge_pkg::ROWS_RESET;
         generations_ff <= '0;
         rows_loaded_ff <= '0;
         gens_left_ff   <= '0;
         row_ff         <= '0;
         old_above_ff   <= '0;
         old_cur_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         grid_cols_ff   <= grid_cols_in;
         grid_rows_ff   <= grid_rows_in;
         generations_ff <= generations_in;
         rows_loaded_ff <= rows_loaded_in;
         gens_left_ff   <= gens_left_in;
         row_ff         <= row_in;
         old_above_ff   <= old_above_in;
         old_cur_ff     <= old_cur_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // response payload carries no reset
   always_ff @(posedge clock) begin
      rsp_cells_ff <= rsp_cells_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_cells = rsp_cells_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_last_row  = rsp_last_ff;

endmodule
